@@ hw/rtl/bed_pkg.sv @@
// Package for the button event detector: request and result payload types,
// configuration register set, register indexes, reset values and mode codes.
// No dependencies.
package bed_pkg;

  // One scan tick: raw pin level and millisecond timestamp.
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  // Events and status for one tick.
  typedef struct packed {
    logic        press_event;
    logic        release_event;
    logic        click_event;
    logic        double_click_event;
    logic        long_press_event;
    logic        long_repeat_event;
    logic        is_held;
    logic [31:0] hold_time;
  } out_t;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic        press_level;
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [15:0] repeat_interval;
    logic [15:0] double_click_window;
  } cfg_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_WINDOW = 3'd4;

  localparam logic        RST_PRESS_LEVEL         = 1'b0;
  localparam logic [15:0] RST_DEBOUNCE_TIME       = 16'd20;
  localparam logic [15:0] RST_LONG_PRESS_TIME     = 16'd1000;
  localparam logic [15:0] RST_REPEAT_INTERVAL     = 16'd200;
  localparam logic [15:0] RST_DOUBLE_CLICK_WINDOW = 16'd400;

  // Mode codes; code 3 is unused and acts like idle.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PRESSED = 2'd1;
  localparam logic [1:0] MODE_WAIT    = 2'd2;

  localparam logic [1:0] CLICKS_NONE = 2'd0;
  localparam logic [1:0] CLICKS_ONE  = 2'd1;
  localparam logic [1:0] CLICKS_TWO  = 2'd2;

endpackage

@@ hw/rtl/bed_core.sv @@
// Button event detector core: debounce and mode state plus the per-tick
// event logic. Updates state when step_i is high. Depends on bed_pkg.
module bed_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  bed_pkg::in_t in_i,
  input  bed_pkg::cfg_t cfg_i,
  output bed_pkg::out_t res_o
);

  typedef logic [TIME_BITS-1:0] tm_t;

  logic       last_raw_q, last_raw_d;
  logic       stable_q, stable_d;
  logic       db_run_q, db_run_d;
  tm_t        db_start_q, db_start_d;
  tm_t        press_time_q, press_time_d;
  tm_t        rel_time_q, rel_time_d;
  logic [1:0] clicks_q, clicks_d;
  logic       long_done_q, long_done_d;
  tm_t        rep_due_q, rep_due_d;
  logic [1:0] mode_q, mode_d;

  tm_t  now;
  tm_t  db_t, lp_t, ri_t, dcw_t;
  tm_t  db_diff, held_old, rel_diff, rep_diff_old, rep_neg, rep_diff, held;
  tm_t  now_plus_ri;
  logic raw, changed, db_fire, press, rel_evt;
  logic lp_on, ri_on, dcw_on, ld1, long_fire, rep_fire, rel_set;
  logic ev_click_rel, ev_click_wait, ev_dbl;

  // All differences are taken in parallel from registered state; a value
  // written this tick would give a difference of zero and is special-cased.
  always_comb begin
    now          = in_i.now_ms[TIME_BITS-1:0];
    db_t         = tm_t'(cfg_i.debounce_time);
    lp_t         = tm_t'(cfg_i.long_press_time);
    ri_t         = tm_t'(cfg_i.repeat_interval);
    dcw_t        = tm_t'(cfg_i.double_click_window);
    lp_on        = (cfg_i.long_press_time != '0);
    ri_on        = (cfg_i.repeat_interval != '0);
    dcw_on       = (cfg_i.double_click_window != '0);
    db_diff      = now - db_start_q;
    held_old     = now - press_time_q;
    rel_diff     = now - rel_time_q;
    rep_diff_old = now - rep_due_q;
    rep_neg      = tm_t'(0) - ri_t;
    now_plus_ri  = now + ri_t;

    raw     = (in_i.pin_level == cfg_i.press_level);
    changed = (raw != last_raw_q);

    last_raw_d = raw;
    db_start_d = changed ? now : db_start_q;
    db_fire    = changed ? (cfg_i.debounce_time == '0)
                         : (db_run_q && (db_diff >= db_t));
    db_run_d   = (changed | db_run_q) & ~db_fire;

    press   = db_fire && (raw != stable_q) && raw;
    rel_evt = db_fire && (raw != stable_q) && !raw;

    stable_d     = (db_fire && (raw != stable_q)) ? raw : stable_q;
    press_time_d = press ? now : press_time_q;
    rel_time_d   = rel_time_q;
    clicks_d     = clicks_q;
    mode_d       = mode_q;
    ev_click_rel = 1'b0;
    ev_dbl       = 1'b0;
    rel_set      = 1'b0;

    if (press) begin
      if (mode_q == bed_pkg::MODE_WAIT && clicks_q == bed_pkg::CLICKS_ONE) begin
        clicks_d = bed_pkg::CLICKS_TWO;
      end
      mode_d = bed_pkg::MODE_PRESSED;
    end else if (rel_evt) begin
      if (lp_on && long_done_q) begin
        clicks_d = bed_pkg::CLICKS_NONE;
        mode_d   = bed_pkg::MODE_IDLE;
      end else if (dcw_on && (!lp_on || held_old < lp_t)) begin
        rel_time_d = now;
        rel_set    = 1'b1;
        if (clicks_q != bed_pkg::CLICKS_NONE) begin
          clicks_d = bed_pkg::CLICKS_NONE;
          ev_dbl   = 1'b1;
          mode_d   = bed_pkg::MODE_IDLE;
        end else begin
          clicks_d = bed_pkg::CLICKS_ONE;
          mode_d   = bed_pkg::MODE_WAIT;
        end
      end else begin
        ev_click_rel = 1'b1;
        clicks_d     = bed_pkg::CLICKS_NONE;
        mode_d       = bed_pkg::MODE_IDLE;
      end
    end

    // Long press and repeat; a press this tick means zero hold time.
    held      = press ? tm_t'(0) : held_old;
    ld1       = press ? 1'b0 : long_done_q;
    long_fire = stable_d && lp_on && !ld1 && (held >= lp_t);
    long_done_d = ld1 | long_fire;
    rep_diff  = (long_fire && ri_on) ? rep_neg : rep_diff_old;
    rep_fire  = stable_d && lp_on && long_done_d && ri_on && !rep_diff[TIME_BITS-1];
    rep_due_d = ((long_fire && ri_on) || rep_fire) ? now_plus_ri : rep_due_q;

    // Double-click window timeout; cannot expire on the tick it opens.
    ev_click_wait = (mode_d == bed_pkg::MODE_WAIT) && (clicks_d == bed_pkg::CLICKS_ONE)
                    && !rel_set && (rel_diff >= dcw_t);
    if (ev_click_wait) begin
      clicks_d = bed_pkg::CLICKS_NONE;
      mode_d   = bed_pkg::MODE_IDLE;
    end

    res_o.press_event        = press;
    res_o.release_event      = rel_evt;
    res_o.click_event        = ev_click_rel | ev_click_wait;
    res_o.double_click_event = ev_dbl;
    res_o.long_press_event   = long_fire;
    res_o.long_repeat_event  = rep_fire;
    res_o.is_held            = stable_d;
    res_o.hold_time          = stable_d ? 32'(held) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q   <= 1'b0;
      stable_q     <= 1'b0;
      db_run_q     <= 1'b0;
      db_start_q   <= '0;
      press_time_q <= '0;
      rel_time_q   <= '0;
      clicks_q     <= bed_pkg::CLICKS_NONE;
      long_done_q  <= 1'b0;
      rep_due_q    <= '0;
      mode_q       <= bed_pkg::MODE_IDLE;
    end else if (step_i) begin
      last_raw_q   <= last_raw_d;
      stable_q     <= stable_d;
      db_run_q     <= db_run_d;
      db_start_q   <= db_start_d;
      press_time_q <= press_time_d;
      rel_time_q   <= rel_time_d;
      clicks_q     <= clicks_d;
      long_done_q  <= long_done_d;
      rep_due_q    <= rep_due_d;
      mode_q       <= mode_d;
    end
  end

endmodule

@@ hw/rtl/button_event_detector_top.sv @@
// Top level of the button event detector: request and result channels,
// configuration registers, pipeline registers. Depends on bed_pkg, bed_core.
// Usage:
// - Request channel (in_valid_i / in_stall_o / in_req_i): one scan tick per
//   request, carrying the raw pin level and a millisecond timestamp.
// - Result channel (out_valid_o / out_stall_i / out_res_o): exactly one
//   result per request, in order: event pulses for that tick, the debounced
//   level and the hold time.
// - Configuration channel (cfg_valid_i / cfg_ready_o, cfg_index_i,
//   cfg_data_i): register 0 active level, 1 debounce time, 2 long press
//   time, 3 repeat interval, 4 double-click window. Other indexes are
//   ignored. Write only while no request is in flight.
// - Path: an accepted request waits in the input register; the core steps and
//   the result register loads from it once that register is free or draining.
// - Throughput: one request per cycle while not stalled; the per-tick logic is
//   parallel TIME_BITS-wide subtracts and compares between the two registers.
// - Stall: when the result register is full and stalled, the input register
//   holds and in_stall_o rises only once the input register is also full.
// - Reset: button released, idle, no debounce running, registers at their
//   defaults, both pipeline registers empty.
module button_event_detector_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bed_pkg::in_t                       in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bed_pkg::out_t                      out_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bed_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bed_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers
  bed_pkg::cfg_t cfg_q, cfg_d;

  // Input register stage
  logic          in_vld_q, in_vld_d;
  bed_pkg::in_t  in_q;

  // Result register stage
  logic          out_vld_q, out_vld_d;
  bed_pkg::out_t out_q;
  bed_pkg::out_t res;

  logic in_acc, advance;

  // The core step fires when the result register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_acc | (in_vld_q & ~advance);
  assign out_vld_d = advance | (out_vld_q & out_stall_i);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bed_pkg::CFG_PRESS_LEVEL:         cfg_d.press_level         = cfg_data_i[0];
        bed_pkg::CFG_DEBOUNCE_TIME:       cfg_d.debounce_time       = cfg_data_i;
        bed_pkg::CFG_LONG_PRESS_TIME:     cfg_d.long_press_time     = cfg_data_i;
        bed_pkg::CFG_REPEAT_INTERVAL:     cfg_d.repeat_interval     = cfg_data_i;
        bed_pkg::CFG_DOUBLE_CLICK_WINDOW: cfg_d.double_click_window = cfg_data_i;
        default:                          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_level         <= bed_pkg::RST_PRESS_LEVEL;
      cfg_q.debounce_time       <= bed_pkg::RST_DEBOUNCE_TIME;
      cfg_q.long_press_time     <= bed_pkg::RST_LONG_PRESS_TIME;
      cfg_q.repeat_interval     <= bed_pkg::RST_REPEAT_INTERVAL;
      cfg_q.double_click_window <= bed_pkg::RST_DOUBLE_CLICK_WINDOW;
      in_vld_q                  <= 1'b0;
      out_vld_q                 <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_req_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  bed_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

@@ hw/rtl/bed_checker.sv @@
// Port-level checker for the button event detector, bound to the top level.
// Depends on bed_pkg and button_event_detector_top.
module bed_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bed_pkg::out_t out_res_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // Press and release cannot both be confirmed on one tick.
  a_press_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.press_event && out_res_o.release_event))
    else $error("press and release together");

  // Hold time reads zero whenever the button is not held.
  a_hold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.is_held |-> out_res_o.hold_time == 32'd0)
    else $error("hold time nonzero while released");

  // A double click completes on a release.
  a_dbl_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.double_click_event |-> out_res_o.release_event)
    else $error("double click without release");

  // Long press and repeat only while held.
  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.long_press_event || out_res_o.long_repeat_event)
    |-> out_res_o.is_held)
    else $error("long press event while released");

endmodule

bind button_event_detector_top bed_checker u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
